>>> hdl/vpla_pkg.sv
package vpla_pkg;

  localparam int CoordW = 32;
  localparam int ProdW  = 2 * CoordW;
  localparam int RootW  = ProdW / 2;
  localparam int LevelW = 8;
  localparam int RadW   = 31;
  localparam int NumW   = LevelW + RadW;

  localparam int SqCntW  = $clog2(CoordW);
  localparam int RtCntW  = $clog2(RootW);
  localparam int DivCntW = $clog2(LevelW);

  localparam logic [LevelW-1:0] SumMax = 8'd255;

  // light operands handed to the falloff unit
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [RadW-1:0]   near_r;
    logic [RadW-1:0]   far_r;
  } fo_op_t;

endpackage

>>> hdl/vertex_point_light_accumulator.sv
// Point-light vertex lighting with linear falloff. Each item pairs a vertex
// with a light (16.16 coordinates); the block adds the light's contribution
// to a running sum saturating at 255, and an item with last_light set emits
// that sum on brightness_o and clears it. One item at a time, passing through
// the bit-serial squarers (three axes side by side), the two-bit-per-cycle
// square root and the bit-serial falloff divider (skipped when the distance
// is at or inside the near radius or at or beyond the far radius). A result
// waiting in the output register does not hold off the next item; only a
// second result stalls until it is taken.
module vertex_point_light_accumulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [vpla_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0] vertex_z_i,
  input  logic signed [vpla_pkg::CoordW-1:0] light_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0] light_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0] light_z_i,
  input  logic        [vpla_pkg::LevelW-1:0] light_level_i,
  input  logic        [vpla_pkg::RadW-1:0]   near_radius_i,
  input  logic        [vpla_pkg::RadW-1:0]   far_radius_i,
  input  logic                               last_light_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [vpla_pkg::LevelW-1:0] brightness_o
);
  import vpla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_RT   = 5'b00100,
    S_FO   = 5'b01000,
    S_ACC  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              accept;
  fo_op_t            op_q;
  logic              last_q;
  logic [LevelW-1:0] sum_q, sum_d, bright_q;
  logic              out_valid_q;

  logic              sq_done, rt_done, fo_done;
  logic [ProdW-1:0]  d2;
  logic [RootW-1:0]  root_dist;
  logic [LevelW-1:0] inc;
  logic [LevelW:0]   sum_ext;
  logic [LevelW-1:0] sum_sat;
  logic              emit, fold;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  vpla_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .vtx_x_i (vertex_x_i),
    .vtx_y_i (vertex_y_i),
    .vtx_z_i (vertex_z_i),
    .lgt_x_i (light_x_i),
    .lgt_y_i (light_y_i),
    .lgt_z_i (light_z_i),
    .done_o  (sq_done),
    .d2_o    (d2)
  );

  vpla_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_done),
    .rad_i   (d2),
    .done_o  (rt_done),
    .root_o  (root_dist)
  );

  vpla_falloff u_falloff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_done),
    .dist_i  (root_dist),
    .op_i    (op_q),
    .done_o  (fo_done),
    .inc_o   (inc)
  );

  always_comb begin
    sum_ext = {1'b0, sum_q} + {1'b0, inc};
    sum_sat = sum_ext[LevelW] ? SumMax : sum_ext[LevelW-1:0];
    fold    = (state_q == S_ACC) && !last_q;
    emit    = (state_q == S_ACC) && last_q && (!out_valid_q || out_ready_i);
    sum_d   = sum_q;
    if (fold) begin
      sum_d = sum_sat;
    end else if (emit) begin
      sum_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_SQ;
      S_SQ:   if (sq_done) state_d = S_RT;
      S_RT:   if (rt_done) state_d = S_FO;
      S_FO:   if (fo_done) state_d = S_ACC;
      S_ACC:  if (fold || emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.level  <= light_level_i;
      op_q.near_r <= near_radius_i;
      op_q.far_r  <= far_radius_i;
      last_q      <= last_light_i;
    end
    if (emit) begin
      bright_q <= sum_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign brightness_o = bright_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_sq_done_in_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQ))
    else $error("squarer finished outside its phase");

  a_fo_done_in_fo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fo_done |-> (state_q == S_FO))
    else $error("falloff finished outside its phase");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_o && (sum_q == '0) && (state_q == S_IDLE)))
    else $error("emitted item did not clear the running sum");
`endif

endmodule

>>> hdl/vpla_sqsum.sv
module vpla_sqsum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   vtx_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   vtx_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   vtx_z_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   lgt_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   lgt_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0]   lgt_z_i,
  output logic                                 done_o,
  output logic        [vpla_pkg::ProdW-1:0]    d2_o
);
  import vpla_pkg::*;

  logic [CoordW-1:0] diff   [3];
  logic [CoordW-1:0] mag    [3];
  logic [CoordW-1:0] mag_q  [3];
  logic [ProdW-1:0]  prod_q [3];
  logic [ProdW-1:0]  prod_d [3];
  logic [CoordW:0]   hi_sum [3];
  logic [ProdW-1:0]  d2_q;

  logic              busy_q, add_q, done_q;
  logic [SqCntW-1:0] cnt_q;
  logic              last_step;

  assign last_step = busy_q && (cnt_q == SqCntW'(CoordW - 1));

  always_comb begin
    diff[0] = CoordW'(lgt_x_i) - CoordW'(vtx_x_i);
    diff[1] = CoordW'(lgt_y_i) - CoordW'(vtx_y_i);
    diff[2] = CoordW'(lgt_z_i) - CoordW'(vtx_z_i);
    for (int i = 0; i < 3; i++) begin
      mag[i] = diff[i][CoordW-1] ? (CoordW'(0) - diff[i]) : diff[i];
      // one multiplier bit per cycle: add at the top, shift the pair right
      hi_sum[i] = {1'b0, prod_q[i][ProdW-1:CoordW]}
                + {1'b0, (prod_q[i][0] ? mag_q[i] : CoordW'(0))};
      prod_d[i] = {hi_sum[i], prod_q[i][CoordW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      add_q  <= last_step;
      done_q <= add_q;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + SqCntW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= mag[i];
        prod_q[i] <= {CoordW'(0), mag[i]};
      end
    end else if (busy_q) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    // each square is at most 2^62, so the sum of three fits
    if (add_q) begin
      d2_q <= prod_q[0] + prod_q[1] + prod_q[2];
    end
  end

  assign done_o = done_q;
  assign d2_o   = d2_q;

endmodule

>>> hdl/vpla_sqrt.sv
module vpla_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [vpla_pkg::ProdW-1:0]      rad_i,
  output logic                            done_o,
  output logic [vpla_pkg::RootW-1:0]      root_o
);
  import vpla_pkg::*;

  logic [ProdW-1:0]  rad_q;
  logic [RootW:0]    rem_q;
  logic [RootW-1:0]  root_q;
  logic [RootW+2:0]  rem_t, trial, diff;
  logic              ge;

  logic              busy_q, done_q;
  logic [RtCntW-1:0] cnt_q;
  logic              last_step;

  assign last_step = busy_q && (cnt_q == RtCntW'(RootW - 1));

  // two radicand bits per cycle; remainder stays within 2*root
  always_comb begin
    rem_t = {rem_q, rad_q[ProdW-1:ProdW-2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + RtCntW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[ProdW-3:0], 2'b00};
      rem_q  <= ge ? diff[RootW:0] : rem_t[RootW:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> hdl/vpla_falloff.sv
module vpla_falloff (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [vpla_pkg::RootW-1:0]      dist_i,
  input  vpla_pkg::fo_op_t                op_i,
  output logic                            done_o,
  output logic [vpla_pkg::LevelW-1:0]     inc_o
);
  import vpla_pkg::*;

  logic               near_hit, far_hit;
  logic [RadW-1:0]    span, denom;
  logic [NumW-1:0]    num;
  logic [RadW-1:0]    denom_q, rem_q;
  logic [LevelW-1:0]  low_q;
  logic [RadW:0]      rem_t, sub;
  logic               ge;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic               last_step;

  assign last_step = busy_q && (cnt_q == DivCntW'(LevelW - 1));

  always_comb begin
    near_hit = (dist_i <= RootW'(op_i.near_r));
    far_hit  = (RootW'(op_i.far_r) <= dist_i);
    // between the radii dist < far < 2^31
    span     = op_i.far_r - dist_i[RadW-1:0];
    denom    = op_i.far_r - op_i.near_r;
    num      = NumW'(op_i.level) * NumW'(span);
    rem_t    = {rem_q, low_q[LevelW-1]};
    ge       = (rem_t >= {1'b0, denom_q});
    sub      = rem_t - {1'b0, denom_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= !near_hit && !far_hit;
        done_q <= near_hit || far_hit;
        cnt_q  <= '0;
      end else begin
        done_q <= last_step;
        if (busy_q) begin
          cnt_q <= cnt_q + DivCntW'(1);
          if (last_step) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  // quotient is below level, so it takes 8 bits: the top of the numerator
  // starts below the divisor and only the low 8 bits are shifted in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      denom_q <= denom;
      if (near_hit) begin
        low_q <= op_i.level;
      end else if (far_hit) begin
        low_q <= '0;
      end else begin
        rem_q <= num[NumW-1:LevelW];
        low_q <= num[LevelW-1:0];
      end
    end else if (busy_q) begin
      rem_q <= ge ? sub[RadW-1:0] : rem_t[RadW-1:0];
      low_q <= {low_q[LevelW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign inc_o  = low_q;

endmodule

>>> tb/sv/vertex_point_light_accumulator_checker.sv
module vertex_point_light_accumulator_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  vertex_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  vertex_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  vertex_z_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  light_x_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  light_y_i,
  input  logic signed [vpla_pkg::CoordW-1:0]  light_z_i,
  input  logic        [vpla_pkg::LevelW-1:0]  light_level_i,
  input  logic        [vpla_pkg::RadW-1:0]    near_radius_i,
  input  logic        [vpla_pkg::RadW-1:0]    far_radius_i,
  input  logic                                last_light_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic        [vpla_pkg::LevelW-1:0]  brightness_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vpla_pkg::*;

  logic [LevelW-1:0] light_sum;
  logic [LevelW-1:0] brightness_q[$];

  // squared magnitude of the 32-bit wrapped difference a - b
  function automatic logic [ProdW-1:0] axis_sq(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic [CoordW-1:0] diff;
    logic [CoordW-1:0] mag;
    diff = a - b;
    mag  = diff[CoordW-1] ? -diff : diff;
    return {{CoordW{1'b0}}, mag} * {{CoordW{1'b0}}, mag};
  endfunction

  // floor square root, one result bit per step from the top down
  function automatic logic [RootW-1:0] floor_root(logic [ProdW-1:0] x);
    logic [RootW-1:0] root;
    logic [RootW-1:0] trial;
    root = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      trial = root | (RootW'(1) << b);
      if ({{RootW{1'b0}}, trial} * {{RootW{1'b0}}, trial} <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [LevelW-1:0] light_share(logic [RootW-1:0] dist_v,
                                                    logic [LevelW-1:0] level,
                                                    logic [RadW-1:0] near_r,
                                                    logic [RadW-1:0] far_r);
    logic [63:0] quot;
    if (dist_v <= {1'b0, near_r}) return level;
    if ({1'b0, far_r} <= dist_v) return '0;
    // here near < dist < far, so both differences are positive
    quot = ({56'd0, level} * ({33'd0, far_r} - {32'd0, dist_v}))
           / ({33'd0, far_r} - {33'd0, near_r});
    return quot[LevelW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [ProdW-1:0]  dist_sq;
    logic [RootW-1:0]  root_v;
    logic [LevelW:0]   total;
    logic [LevelW-1:0] want;
    if (!rst_ni) begin
      light_sum = '0;
      brightness_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (brightness_q.size() == 0) begin
          $error("brightness: no item pending, expected none, actual %0d", brightness_i);
          fail_count_o++;
        end else begin
          want = brightness_q.pop_front();
          if (brightness_i !== want) begin
            $error("brightness: expected %0d, actual %0d", want, brightness_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        dist_sq = axis_sq(light_x_i, vertex_x_i) + axis_sq(light_y_i, vertex_y_i)
                  + axis_sq(light_z_i, vertex_z_i);
        root_v = floor_root(dist_sq);
        total  = {1'b0, light_sum}
                 + {1'b0, light_share(root_v, light_level_i, near_radius_i, far_radius_i)};
        light_sum = (total > SumMax) ? SumMax : total[LevelW-1:0];
        if (last_light_i) begin
          brightness_q.push_back(light_sum);
          light_sum = '0;
        end
      end
      pending_o = brightness_q.size();
    end
  end

endmodule

>>> tb/sv/vertex_point_light_accumulator_tb.sv
module vertex_point_light_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vpla_pkg::*;

  localparam int RandItems = 1700;
  localparam int HoldCycles = 400;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [CoordW-1:0] vertex_x, vertex_y, vertex_z;
  logic signed [CoordW-1:0] light_x, light_y, light_z;
  logic        [LevelW-1:0] light_level;
  logic        [RadW-1:0]   near_radius, far_radius;
  logic                     last_light;
  logic                     out_valid;
  logic                     out_ready;
  logic        [LevelW-1:0] brightness;

  int   fail_count;
  int   pending;
  int   sent;
  logic quiet;
  logic rx_hold_req;

  vertex_point_light_accumulator DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .vertex_x_i    (vertex_x),
    .vertex_y_i    (vertex_y),
    .vertex_z_i    (vertex_z),
    .light_x_i     (light_x),
    .light_y_i     (light_y),
    .light_z_i     (light_z),
    .light_level_i (light_level),
    .near_radius_i (near_radius),
    .far_radius_i  (far_radius),
    .last_light_i  (last_light),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .brightness_o  (brightness)
  );

  vertex_point_light_accumulator_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .vertex_x_i    (vertex_x),
    .vertex_y_i    (vertex_y),
    .vertex_z_i    (vertex_z),
    .light_x_i     (light_x),
    .light_y_i     (light_y),
    .light_z_i     (light_z),
    .light_level_i (light_level),
    .near_radius_i (near_radius),
    .far_radius_i  (far_radius),
    .last_light_i  (last_light),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .brightness_i  (brightness),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("vertex_point_light_accumulator_tb failed");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ready = quiet || ($urandom_range(99) >= 35);
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_light(logic [CoordW-1:0] vx, logic [CoordW-1:0] vy,
                            logic [CoordW-1:0] vz, logic [CoordW-1:0] lx,
                            logic [CoordW-1:0] ly, logic [CoordW-1:0] lz,
                            logic [LevelW-1:0] level, logic [RadW-1:0] near_r,
                            logic [RadW-1:0] far_r, logic last);
    if (!quiet && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    vertex_x    = vx;
    vertex_y    = vy;
    vertex_z    = vz;
    light_x     = lx;
    light_y     = ly;
    light_z     = lz;
    light_level = level;
    near_radius = near_r;
    far_radius  = far_r;
    last_light  = last;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [CoordW-1:0] offset_in(int k);
    return ($urandom & ((32'd1 << (k + 1)) - 1)) - (32'd1 << k);
  endfunction

  initial begin : stimulus
    logic [CoordW-1:0] vx, vy, vz, span;
    logic [RadW-1:0]   near_r, far_r, tmp_r;
    logic [31:0]       far_wide;
    logic [LevelW-1:0] level;
    int                k, n_lights;
    bit                hold_done, pause_done;

    rst_n = 1'b0;
    in_valid = 1'b0;
    vertex_x = '0; vertex_y = '0; vertex_z = '0;
    light_x = '0; light_y = '0; light_z = '0;
    light_level = '0; near_radius = '0; far_radius = '0; last_light = 1'b0;
    quiet = 1'b0;
    rx_hold_req = 1'b0;
    sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // coincident points, zero radii
    send_light('0, '0, '0, '0, '0, '0, 8'd255, '0, '0, 1'b1);
    // differences wrap to +-1 at the range ends
    send_light(32'h8000_0000, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0,
               8'd77, 31'd1, 31'd10, 1'b1);
    // largest distance, largest radii
    send_light('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               8'd255, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    // one axis difference of exactly 2^31
    send_light(32'hFFFF_FFFF, '0, '0, 32'h7FFF_FFFF, '0, '0,
               8'd200, '0, 31'h7FFF_FFFF, 1'b1);
    // midway in the falloff band
    send_light('0, '0, '0, 32'h0003_0000, '0, '0, 8'd255, 31'h1_0000, 31'h5_0000, 1'b1);
    // distance on the inner radius, then on the outer radius
    send_light('0, '0, '0, 32'h0005_0000, '0, '0, 8'd100, 31'h5_0000, 31'h9_0000, 1'b0);
    send_light('0, '0, '0, 32'h0005_0000, '0, '0, 8'd100, 31'h1_0000, 31'h5_0000, 1'b0);
    // inverted radii: inside near, then past near
    send_light('0, '0, '0, 32'h0004_0000, '0, '0, 8'd90, 31'h6_0000, 31'h2_0000, 1'b0);
    send_light('0, '0, '0, 32'h0007_0000, '0, '0, 8'd90, 31'h6_0000, 31'h2_0000, 1'b1);
    // equal radii at the distance
    send_light('0, '0, '0, '0, 32'h0004_0000, '0, 8'd50, 31'h4_0000, 31'h4_0000, 1'b1);
    // sum saturates
    send_light('0, '0, '0, '0, '0, '0, 8'd200, '0, 31'd5, 1'b0);
    send_light('0, '0, '0, '0, '0, '0, 8'd200, '0, 31'd5, 1'b0);
    send_light('0, '0, '0, '0, '0, '0, 8'd200, '0, 31'd5, 1'b1);
    send_light('0, '0, '0, 32'h1234_5678, '0, '0, 8'd0, 31'h7FFF_FFFF, '0, 1'b1);
    send_light(32'h4000_0000, '0, '0, '0, '0, '0, 8'd255, 31'h7FFF_FFFF, '0, 1'b1);
    send_light('0, '0, '0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
               8'd255, '0, 31'h7FFF_FFFF, 1'b1);
    send_light(32'hFFFD_0000, 32'hFFFC_0000, '0, '0, '0, '0,
               8'd240, 31'h2_0000, 31'h8_0000, 1'b1);

    while (sent < RandItems + 17) begin
      if (!hold_done && sent >= 400) begin
        rx_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && sent >= 1000) begin
        wait (pending == 0);
        @(negedge clk);
        pause_done = 1'b1;
      end
      quiet = (sent >= 1200 && sent < 1450);

      if ($urandom_range(99) < 20) begin
        // unstructured item: every bit free
        send_light($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   LevelW'($urandom), RadW'($urandom), RadW'($urandom),
                   1'($urandom_range(1)));
      end else begin
        // one vertex lit by a short run of nearby lights
        n_lights = $urandom_range(1, 6);
        vx = $urandom;
        vy = $urandom;
        vz = $urandom;
        for (int i = 0; i < n_lights; i++) begin
          k = $urandom_range(4, 29);
          span = 32'd1 << k;
          near_r = RadW'($urandom_range(0, span));
          far_wide = {1'b0, near_r} + $urandom_range(0, 2 * span);
          far_r = far_wide[31] ? 31'h7FFF_FFFF : far_wide[RadW-1:0];
          case ($urandom_range(19))
            0, 1: begin
              tmp_r = near_r;
              near_r = far_r;
              far_r = tmp_r;
            end
            2: far_r = near_r;
            default: ;
          endcase
          case ($urandom_range(9))
            0: level = '0;
            1, 2, 3, 4: level = LevelW'($urandom_range(128, 255));
            default: level = LevelW'($urandom_range(0, 255));
          endcase
          send_light(vx, vy, vz, vx + offset_in(k), vy + offset_in(k), vz + offset_in(k),
                     level, near_r, far_r, i == n_lights - 1);
        end
      end
    end

    quiet = 1'b0;
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("vertex_point_light_accumulator_tb passed");
    end else begin
      $display("vertex_point_light_accumulator_tb failed");
    end
    $finish;
  end

endmodule

>>> vertex_point_light_accumulator.f
hdl/vpla_pkg.sv
hdl/vpla_sqsum.sv
hdl/vpla_sqrt.sv
hdl/vpla_falloff.sv
hdl/vertex_point_light_accumulator.sv
tb/sv/vertex_point_light_accumulator_checker.sv
tb/sv/vertex_point_light_accumulator_tb.sv
